@@ hdl/sequential_sector_readahead_core_assert.svh @@
// Assertion macros for the sector read-ahead core.
// Concurrent checks with |-> and |=>; empty when SYNTHESIS is defined.
`ifndef SEQUENTIAL_SECTOR_READAHEAD_CORE_ASSERT_SVH
`define SEQUENTIAL_SECTOR_READAHEAD_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SSRA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define SSRA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SSRA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define SSRA_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

@@ hdl/ssra_pkg.sv @@
// Shared types and constants for the sector read-ahead core.
// No dependencies; used by ssra_step and the top level.
package ssra_pkg;

  localparam int SLOTS      = 256;
  localparam int MAX_AHEAD  = 16;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int LBA_W      = 24;
  localparam int COUNT_W    = 8;
  localparam int CMD_W      = 2;

  localparam logic [COUNT_W-1:0] INITIAL_AHEAD = COUNT_W'(1);
  localparam logic [COUNT_W-1:0] BURST_AHEAD   = COUNT_W'(2);
  localparam logic [COUNT_W-1:0] COUNT_MAX     = {COUNT_W{1'b1}};
  localparam logic [SLOT_W-1:0]  SLOT_LAST     = SLOT_W'(SLOTS - 1);

  // Command codes; the unused code behaves as a tick.
  localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REQUEST = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EJECT   = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [LBA_W-1:0] request_lba;
    logic             eject_flag;
  } in_item_t;

  typedef struct packed {
    logic             fetch_valid;
    logic [LBA_W-1:0] fetch_lba;
    logic [7:0]       fetch_slot;
    logic             flush;
    logic             eject_done;
  } out_item_t;

  typedef struct packed {
    logic [LBA_W-1:0]   ahead_lba;
    logic [COUNT_W-1:0] ahead_count;
    logic [LBA_W-1:0]   previous_lba;
    logic               previous_valid;
    logic [SLOT_W-1:0]  write_slot;
    logic               ejected;
  } ra_state_t;

endpackage

@@ hdl/ssra_step.sv @@
// One controller pass: next read-ahead state and the result item.
// Purely combinational; depends on ssra_pkg.
module ssra_step (
  input  ssra_pkg::ra_state_t          cur,
  input  ssra_pkg::in_item_t           item,
  input  logic [ssra_pkg::LBA_W-1:0]   leadout_lba,
  output ssra_pkg::ra_state_t          nxt,
  output ssra_pkg::out_item_t          res
);

  localparam logic signed [ssra_pkg::LBA_W-1:0] MAX_DIST = ssra_pkg::LBA_W'(ssra_pkg::MAX_AHEAD);

  logic                                sequential;
  logic                                same_lba;
  logic signed [ssra_pkg::LBA_W-1:0]   lead;
  logic [ssra_pkg::SLOT_W+7:0]         slot_ext;
  ssra_pkg::ra_state_t                 mid;

  // Next-sector test without wrap at the top address.
  assign sequential = cur.previous_valid &&
    ({1'b0, item.request_lba} == ({1'b0, cur.previous_lba} + (ssra_pkg::LBA_W + 1)'(1)));
  assign same_lba   = cur.previous_valid && (item.request_lba == cur.previous_lba);
  assign lead       = $signed(cur.ahead_lba - item.request_lba);

  always_comb begin
    mid = cur;
    res = '0;
    case (item.command)
      ssra_pkg::CMD_REQUEST: begin
        if (sequential) begin
          if (lead == MAX_DIST) begin
            mid.ahead_count = ssra_pkg::INITIAL_AHEAD;
          end else if (lead < MAX_DIST) begin
            mid.ahead_count = ssra_pkg::BURST_AHEAD;
          end else if (cur.ahead_count != ssra_pkg::COUNT_MAX) begin
            mid.ahead_count = cur.ahead_count + ssra_pkg::COUNT_W'(1);
          end
        end else if (!same_lba) begin
          mid.ahead_lba   = item.request_lba;
          mid.ahead_count = ssra_pkg::INITIAL_AHEAD;
        end
        mid.previous_lba   = item.request_lba;
        mid.previous_valid = 1'b1;
      end
      ssra_pkg::CMD_EJECT: begin
        res.eject_done = 1'b1;
        if (item.eject_flag != cur.ejected) begin
          mid         = '0;
          mid.ejected = item.eject_flag;
          res.flush   = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // Stop at the lead-out sector.
    if (mid.ahead_lba == leadout_lba) begin
      mid.ahead_count = '0;
    end

    // Issue at most one fetch into the next ring slot.
    nxt      = mid;
    slot_ext = {8'b0, mid.write_slot};
    if (mid.ahead_count != '0) begin
      res.fetch_valid = 1'b1;
      res.fetch_lba   = mid.ahead_lba;
      res.fetch_slot  = slot_ext[7:0];
      nxt.write_slot  = (mid.write_slot == ssra_pkg::SLOT_LAST) ? '0 :
                        mid.write_slot + ssra_pkg::SLOT_W'(1);
      nxt.ahead_lba   = mid.ahead_lba + ssra_pkg::LBA_W'(1);
      nxt.ahead_count = mid.ahead_count - ssra_pkg::COUNT_W'(1);
    end
  end

endmodule

@@ hdl/sequential_sector_readahead_core.sv @@
// Top level of the sequential sector read-ahead controller.
// Depends on ssra_pkg, ssra_step and sequential_sector_readahead_core_assert.svh.
//
// Usage:
//   in channel (in_valid/in_ready/in_item): one transaction per controller
//     pass: a tick, a sector request, or a new eject state.
//   out channel (out_valid/out_ready/out_item): exactly one result per pass,
//     carrying at most one sector fetch with its ring slot, plus flush and
//     eject acknowledge flags.
//   cfg_wen/cfg_wdata: write the lead-out sector; write only while idle.
// Output: the result is registered and appears in the cycle after its input is taken.
// Throughput: one transaction per cycle while out_ready is high; the pass is a compare,
//   a subtract and increments between the state registers and the result register.
// Reset: all read-ahead state, the eject state and the lead-out sector clear
//   to zero, and the result register empties.
// Stall: while the result register holds an untaken result, in_ready follows
//   out_ready, so a new transaction enters in the same cycle the old result
//   leaves; otherwise the input waits with no loss.
`include "sequential_sector_readahead_core_assert.svh"

module sequential_sector_readahead_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wen,
  input  logic [ssra_pkg::LBA_W-1:0]   cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  ssra_pkg::in_item_t           in_item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output ssra_pkg::out_item_t          out_item
);

  logic [ssra_pkg::LBA_W-1:0] leadout_lba;
  ssra_pkg::ra_state_t        state;
  ssra_pkg::ra_state_t        state_next;
  ssra_pkg::out_item_t        result;
  logic                       in_fire;

  // Accept whenever the result register is empty or is being drained.
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  ssra_step u_step (
    .cur         (state),
    .item        (in_item),
    .leadout_lba (leadout_lba),
    .nxt         (state_next),
    .res         (result)
  );

  // Lead-out register: take every write directly.
  always_ff @(posedge clk) begin
    if (rst) begin
      leadout_lba <= '0;
    end else if (cfg_wen) begin
      leadout_lba <= cfg_wdata;
    end
  end

  // Advance the controller state once per accepted pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (in_fire) begin
      state <= state_next;
    end
  end

  // Result register: load on accept, drop when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_item <= result;
    end
  end

  `SSRA_ASSERT_IMPLY(a_idle_fields_zero, clk, rst, out_valid && !out_item.fetch_valid, (out_item.fetch_lba == '0) && (out_item.fetch_slot == '0), "idle result carries fetch fields")
  `SSRA_ASSERT_IMPLY(a_flush_acked, clk, rst, out_valid && out_item.flush, out_item.eject_done, "flush without eject acknowledge")
  `SSRA_ASSERT_NEXT(a_flush_clears, clk, rst, in_fire && result.flush, !state.previous_valid && (state.write_slot == '0) && (state.ahead_count == '0), "flush left read-ahead state")
  `SSRA_ASSERT_NEXT(a_no_grow_on_tick, clk, rst, in_fire && (in_item.command != ssra_pkg::CMD_REQUEST), state.ahead_count <= $past(state.ahead_count), "ahead count grew without a request")

endmodule
